FILE: sv/pip_pkg.sv
// Package for the point-in-polygon crossing block.
// Holds the coordinate width, the vertex/result payload structs and the edge flag struct.
// No dependencies.
`default_nettype none

package pip_pkg;

    // Coordinate width, two's complement
    localparam int COORD_WIDTH = 16;
    // Coordinate minus query: one extra bit
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    // Product of two differences
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t vertex_x;
        coord_t vertex_y;
        logic   first_vertex;
        logic   last_vertex;
    } pip_vertex_t;

    typedef struct packed {
        logic inside_res;
        logic on_boundary;
    } pip_result_t;

    // Parity toggles requested by one edge
    typedef struct packed {
        logic right;
        logic left;
    } pip_toggle_t;

endpackage

`default_nettype wire

FILE: sv/point_in_polygon_crossing_top.sv
// Point-in-polygon crossing test, top level: input register, parity state, result register.
// Instantiates two pip_edge_test units (edge to previous vertex, closing edge).
// Depends on pip_pkg.
//
// Vertices stream in one per transfer, in order, each carrying the query point; the query
// is taken from the transfer marked first_vertex. Every later vertex tests the edge back to
// the previous one, and the transfer marked last_vertex also tests the closing edge and
// yields one result: inside_res (inside or on the boundary) and on_boundary (query equals
// a vertex or lies on an edge). Throughput is one vertex per clock unless a last vertex is
// held by an unaccepted result; both edge units and the parity update resolve combinationally
// on the input register, and a result appears in the output register the cycle after its
// last vertex retires. Accumulation continues from the kept state without a new first_vertex.
`default_nettype none

module point_in_polygon_crossing_top (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      vertex_valid,
    output logic                     vertex_ready,
    input  wire pip_pkg::pip_vertex_t vertex,
    output logic                     result_valid,
    input  wire                      result_ready,
    output pip_pkg::pip_result_t     result
);
    import pip_pkg::*;

    pip_vertex_t item_reg;
    logic        item_valid_reg;

    coord_t      start_x_reg;
    coord_t      start_y_reg;
    coord_t      prior_x_reg;
    coord_t      prior_y_reg;
    coord_t      held_qx_reg;
    coord_t      held_qy_reg;
    logic        right_parity_reg;
    logic        left_parity_reg;
    logic        vertex_hit_reg;

    pip_result_t result_reg;
    logic        result_valid_reg;

    logic        out_free;
    logic        item_fire;
    logic        vertex_fire;

    coord_t      qx_eff;
    coord_t      qy_eff;
    coord_t      start_x_eff;
    coord_t      start_y_eff;
    pip_toggle_t prior_tog;
    pip_toggle_t close_tog;
    logic        right_mid;
    logic        left_mid;
    logic        right_next;
    logic        left_next;
    logic        hit_next;
    logic        bnd;

    // A non-last vertex never needs the output side
    assign out_free     = !result_valid_reg || result_ready;
    assign item_fire    = item_valid_reg && (!item_reg.last_vertex || out_free);
    assign vertex_ready = !item_valid_reg || item_fire;
    assign vertex_fire  = vertex_valid && vertex_ready;

    assign qx_eff      = item_reg.first_vertex ? item_reg.query_x  : held_qx_reg;
    assign qy_eff      = item_reg.first_vertex ? item_reg.query_y  : held_qy_reg;
    assign start_x_eff = item_reg.first_vertex ? item_reg.vertex_x : start_x_reg;
    assign start_y_eff = item_reg.first_vertex ? item_reg.vertex_y : start_y_reg;

    pip_edge_test u_prior_edge (
        .ax     (item_reg.vertex_x),
        .ay     (item_reg.vertex_y),
        .bx     (prior_x_reg),
        .by     (prior_y_reg),
        .qx     (qx_eff),
        .qy     (qy_eff),
        .toggle (prior_tog)
    );

    pip_edge_test u_close_edge (
        .ax     (start_x_eff),
        .ay     (start_y_eff),
        .bx     (item_reg.vertex_x),
        .by     (item_reg.vertex_y),
        .qx     (qx_eff),
        .qy     (qy_eff),
        .toggle (close_tog)
    );

    // First vertex restarts the parities and tests no edge back
    assign right_mid = item_reg.first_vertex ? 1'b0 : (right_parity_reg ^ prior_tog.right);
    assign left_mid  = item_reg.first_vertex ? 1'b0 : (left_parity_reg ^ prior_tog.left);

    // Closing-edge toggles stay in the state
    assign right_next = right_mid ^ (item_reg.last_vertex && close_tog.right);
    assign left_next  = left_mid ^ (item_reg.last_vertex && close_tog.left);

    assign hit_next = (!item_reg.first_vertex && vertex_hit_reg)
                    || ((item_reg.vertex_x == qx_eff) && (item_reg.vertex_y == qy_eff));

    assign bnd = hit_next || (right_next != left_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (vertex_ready)
        begin
            item_valid_reg <= vertex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vertex_fire)
        begin
            item_reg <= vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            prior_x_reg      <= '0;
            prior_y_reg      <= '0;
            held_qx_reg      <= '0;
            held_qy_reg      <= '0;
            right_parity_reg <= 1'b0;
            left_parity_reg  <= 1'b0;
            vertex_hit_reg   <= 1'b0;
        end
        else if (item_fire)
        begin
            start_x_reg      <= start_x_eff;
            start_y_reg      <= start_y_eff;
            held_qx_reg      <= qx_eff;
            held_qy_reg      <= qy_eff;
            prior_x_reg      <= item_reg.vertex_x;
            prior_y_reg      <= item_reg.vertex_y;
            right_parity_reg <= right_next;
            left_parity_reg  <= left_next;
            vertex_hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_fire && item_reg.last_vertex)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && item_reg.last_vertex)
        begin
            result_reg.inside_res  <= bnd || right_next;
            result_reg.on_boundary <= bnd;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Last vertex always produces a pending result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item_reg.last_vertex |=> result_valid_reg)
        else $error("last vertex retired without a result");

    // A stalled result must hold back a last vertex
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready && item_reg.last_vertex |-> !item_fire)
        else $error("pending result overwritten");

    // Boundary implies inside
    a_bnd_inside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.on_boundary || result_reg.inside_res))
        else $error("on_boundary without inside_res");

    // Query latched from the first vertex
    a_query_latch: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item_reg.first_vertex |=>
            (held_qx_reg == $past(item_reg.query_x)) && (held_qy_reg == $past(item_reg.query_y)))
        else $error("query point not latched on first vertex");

    // Input register only moves when its item retires or is empty
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !item_fire |=> item_valid_reg && $stable(item_reg))
        else $error("unretired vertex lost from input register");

endmodule

`default_nettype wire

FILE: sv/pip_edge_test.sv
// Single-edge crossing test against the horizontal rays through the query point.
// Pure combinational: subtract, two products, one wide subtract and sign checks.
// Depends on pip_pkg.
`default_nettype none

module pip_edge_test (
    input  wire pip_pkg::coord_t      ax,
    input  wire pip_pkg::coord_t      ay,
    input  wire pip_pkg::coord_t      bx,
    input  wire pip_pkg::coord_t      by,
    input  wire pip_pkg::coord_t      qx,
    input  wire pip_pkg::coord_t      qy,
    output pip_pkg::pip_toggle_t      toggle
);
    import pip_pkg::*;

    logic signed [DIFF_WIDTH-1:0] ax_d;
    logic signed [DIFF_WIDTH-1:0] ay_d;
    logic signed [DIFF_WIDTH-1:0] bx_d;
    logic signed [DIFF_WIDTH-1:0] by_d;
    logic signed [PROD_WIDTH-1:0] prod_ab;
    logic signed [PROD_WIDTH-1:0] prod_ba;
    logic signed [PROD_WIDTH:0]   cross_diff;
    logic                         ay_pos;
    logic                         ay_neg;
    logic                         by_pos;
    logic                         by_neg;
    logic                         straddle_r;
    logic                         straddle_l;
    logic                         cross_nz;
    logic                         cross_pos;
    logic                         b_above;
    logic                         right_of_q;

    // Differences fit exactly in one extra bit
    assign ax_d = {ax[COORD_WIDTH-1], ax} - {qx[COORD_WIDTH-1], qx};
    assign ay_d = {ay[COORD_WIDTH-1], ay} - {qy[COORD_WIDTH-1], qy};
    assign bx_d = {bx[COORD_WIDTH-1], bx} - {qx[COORD_WIDTH-1], qx};
    assign by_d = {by[COORD_WIDTH-1], by} - {qy[COORD_WIDTH-1], qy};

    assign prod_ab    = ax_d * by_d;
    assign prod_ba    = ay_d * bx_d;
    assign cross_diff = {prod_ab[PROD_WIDTH-1], prod_ab} - {prod_ba[PROD_WIDTH-1], prod_ba};

    assign ay_pos = !ay_d[DIFF_WIDTH-1] && (|ay_d);
    assign ay_neg = ay_d[DIFF_WIDTH-1];
    assign by_pos = !by_d[DIFF_WIDTH-1] && (|by_d);
    assign by_neg = by_d[DIFF_WIDTH-1];

    assign straddle_r = ay_pos != by_pos;
    assign straddle_l = ay_neg != by_neg;

    // crossing x - query x = cross_diff / (by - ay); a straddle implies by != ay
    assign cross_nz   = |cross_diff;
    assign cross_pos  = !cross_diff[PROD_WIDTH] && cross_nz;
    assign b_above    = by_d > ay_d;
    assign right_of_q = cross_pos == b_above;

    assign toggle.right = straddle_r && cross_nz && right_of_q;
    assign toggle.left  = straddle_l && cross_nz && !right_of_q;

endmodule

`default_nettype wire
